[design/lpbc_pkg.sv]
// ----------------------------------------------------------------------------
// lpbc_pkg
// Shared types and constants of the LRU page buffer controller.
// ----------------------------------------------------------------------------
package lpbc_pkg;

  localparam int SLOTS_DEF = 64;

  localparam int MODE_W = 3;
  localparam int FILE_W = 16;
  localparam int PAGE_W = 32;
  localparam int SLOT_W = 6;
  localparam int TAG_W  = FILE_W + PAGE_W;

  localparam int IN_BITS  = MODE_W + FILE_W + PAGE_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 4 + SLOT_W + FILE_W + PAGE_W + SLOT_W + 1;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [MODE_W-1:0] MODE_GET        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MARK       = 3'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DISCARD    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLUSH_PAGE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FLUSH_FILE = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // request transfer
    logic sweep_go;   // issue memory read at sweep index
    logic upd;        // sweep is a rank update
    logic decide;     // latch promote / demote parameters
    logic commit;     // apply state change, load result
    logic frd;        // flush walk: read tag at index
    logic fout;       // flush walk: load writeback result
    logic walk_next;  // flush walk: skip slot
  } lpbc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_scan;    // incoming mode needs a tag scan
    logic idx_last;
    logic need_upd;
    logic is_flush;
    logic mask_any;
    logic bit_set;
    logic flush_last;
    logic out_free;
  } lpbc_sts_t;

endpackage

[design/lru_page_buffer_controller.sv]
// ----------------------------------------------------------------------------
// lru_page_buffer_controller
// Tag and LRU policy controller for a page buffer with a free-slot FIFO.
// ----------------------------------------------------------------------------
// channel | dir | tdata                                   | tlast
// in_     | in  | mode[2:0] file_id[18:3] page_num[50:19]  | -
// out_    | out | status hit slot fill_needed writeback    | last
//         |     | wb_file wb_page wb_slot dirty           |
//
// One request at a time. Every request but an unused mode sweeps all slots
// through the tag and rank memories; get and a discard hit sweep once more
// to update ranks. Flush file walks the slots one per cycle, but stops at
// each slot to be written back until its result can be sent.
// Reset is synchronous; no clearing pass is needed. A stalled result holds
// the controller in its result state.
module lru_page_buffer_controller #(
  parameter int NUM_SLOTS = lpbc_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [2:0] mode, [18:3] file_id, [50:19] page_num
  input  logic [lpbc_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [0] status, [1] hit, [7:2] slot, [8] fill_needed, [9] writeback,
  // [25:10] wb_file, [57:26] wb_page, [63:58] wb_slot, [64] dirty
  output logic [lpbc_pkg::OUT_W-1:0] out_tdata,
  output logic                       out_tlast
);
  import lpbc_pkg::*;

  lpbc_cmd_t cmd;
  lpbc_sts_t sts;

  lpbc_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpbc_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[design/lpbc_ctl.sv]
// ----------------------------------------------------------------------------
// lpbc_ctl
// Request sequencer: scan, rank update, commit and flush walk.
// ----------------------------------------------------------------------------
module lpbc_ctl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  lpbc_pkg::lpbc_sts_t sts,
  output lpbc_pkg::lpbc_cmd_t cmd
);
  import lpbc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_SCAN_END, ST_DECIDE, ST_UPD, ST_UPD_END,
    ST_RES, ST_FRD, ST_FOUT
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.in_scan ? ST_SCAN : ST_RES;
        end
      end
      ST_SCAN: begin
        cmd.sweep_go = 1'b1;
        if (sts.idx_last) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.is_flush) state_nxt = sts.mask_any ? ST_FRD : ST_RES;
        else              state_nxt = sts.need_upd ? ST_UPD : ST_RES;
      end
      ST_UPD: begin
        cmd.sweep_go = 1'b1;
        cmd.upd      = 1'b1;
        if (sts.idx_last) state_nxt = ST_UPD_END;
      end
      ST_UPD_END: state_nxt = ST_RES;
      ST_RES: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_FRD: begin
        if (sts.bit_set) begin
          cmd.frd   = 1'b1;
          state_nxt = ST_FOUT;
        end else begin
          cmd.walk_next = 1'b1;
        end
      end
      ST_FOUT: begin
        if (sts.out_free) begin
          cmd.fout  = 1'b1;
          state_nxt = sts.flush_last ? ST_IDLE : ST_FRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/lpbc_dp.sv]
// ----------------------------------------------------------------------------
// lpbc_dp
// Tag, rank and free-slot stores, sweep pipeline and result register.
// ----------------------------------------------------------------------------
module lpbc_dp #(
  parameter int NUM_SLOTS = lpbc_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lpbc_pkg::lpbc_cmd_t        cmd,
  output lpbc_pkg::lpbc_sts_t        sts,
  input  logic [lpbc_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [lpbc_pkg::OUT_W-1:0] out_tdata,
  output logic                       out_tlast
);
  import lpbc_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int SUM_W = IDX_W + 1;

  // request
  logic [MODE_W-1:0] req_mode_r;
  logic [FILE_W-1:0] req_file_r;
  logic [PAGE_W-1:0] req_page_r;

  // stores
  logic [TAG_W-1:0]  tag_mem  [NUM_SLOTS];
  logic [IDX_W-1:0]  rank_mem [NUM_SLOTS];
  logic [IDX_W-1:0]  fifo_mem [NUM_SLOTS];
  logic [TAG_W-1:0]  tag_rd_r;
  logic [IDX_W-1:0]  rank_rd_r;
  logic [IDX_W-1:0]  fifo_rd_r;
  logic [NUM_SLOTS-1:0] valid_r, dirty_r, fifo_wm_r, flmask_r;
  logic [IDX_W-1:0]  head_r;
  logic [CNT_W-1:0]  free_cnt_r;

  // sweep
  logic [IDX_W-1:0]  idx_r, rd_idx_r;
  logic              rd_v_r, rd_upd_r;

  // scan results
  logic              match_r;
  logic [IDX_W-1:0]  match_slot_r, match_rank_r;
  logic [IDX_W-1:0]  vic_slot_r, vic_rank_r;
  logic [TAG_W-1:0]  vic_tag_r;

  // promote / demote
  logic [IDX_W-1:0]  prom_slot_r, prom_rank_r;
  logic              prom_all_r, dem_r;

  logic              out_tvalid_r, out_tlast_r;
  logic [OUT_W-1:0]  out_tdata_r;

  logic              idx_last, out_free, free_nz, free_full;
  logic [IDX_W-1:0]  fifo_slot, tail;
  logic [SUM_W-1:0]  tail_sum;
  logic              rd_valid, rd_hit;
  logic              rank_we;
  logic [IDX_W-1:0]  rank_wd;
  logic [NUM_SLOTS-1:0] flmask_rest;
  logic              tag_we;

  logic              r_status, r_hit, r_fill, r_wb, r_dirty;
  logic [SLOT_W-1:0] r_slot, r_wb_slot;
  logic [FILE_W-1:0] r_wb_file;
  logic [PAGE_W-1:0] r_wb_page;

  assign idx_last  = (idx_r == IDX_W'(NUM_SLOTS - 1));
  assign out_free  = !out_tvalid_r || out_tready;
  assign free_nz   = (free_cnt_r != '0);
  assign free_full = (free_cnt_r == CNT_W'(NUM_SLOTS));
  assign fifo_slot = fifo_wm_r[head_r] ? fifo_rd_r : head_r;
  assign tail_sum  = SUM_W'(head_r) + SUM_W'(free_cnt_r);
  assign tail      = (tail_sum >= SUM_W'(NUM_SLOTS)) ?
                     IDX_W'(tail_sum - SUM_W'(NUM_SLOTS)) : IDX_W'(tail_sum);
  assign rd_valid  = valid_r[rd_idx_r];
  assign rd_hit    = rd_valid && (tag_rd_r == {req_file_r, req_page_r});
  assign tag_we    = cmd.commit && (req_mode_r == MODE_GET) && !match_r;

  always_comb begin
    flmask_rest         = flmask_r;
    flmask_rest[idx_r]  = 1'b0;
  end

  always_comb begin
    sts            = '0;
    sts.in_scan    = (in_tdata[MODE_W-1:0] <= MODE_FLUSH_FILE);
    sts.idx_last   = idx_last;
    sts.need_upd   = (req_mode_r == MODE_GET) ||
                     ((req_mode_r == MODE_DISCARD) && match_r);
    sts.is_flush   = (req_mode_r == MODE_FLUSH_FILE);
    sts.mask_any   = |flmask_r;
    sts.bit_set    = flmask_r[idx_r];
    sts.flush_last = (flmask_rest == '0);
    sts.out_free   = out_free;
  end

  // rank update in the second sweep stage
  always_comb begin
    rank_we = 1'b0;
    rank_wd = rank_rd_r;
    if (rd_v_r && rd_upd_r) begin
      if (!dem_r && rd_idx_r == prom_slot_r) begin
        rank_we = 1'b1;
        rank_wd = '0;
      end else if (!dem_r && rd_valid && (prom_all_r || rank_rd_r < prom_rank_r)) begin
        rank_we = 1'b1;
        rank_wd = rank_rd_r + 1'b1;
      end else if (dem_r && rd_valid && rank_rd_r > prom_rank_r) begin
        rank_we = 1'b1;
        rank_wd = rank_rd_r - 1'b1;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.sweep_go || cmd.frd) begin
      tag_rd_r  <= tag_mem[idx_r];
      rank_rd_r <= rank_mem[idx_r];
    end
    if (tag_we) tag_mem[prom_slot_r] <= {req_file_r, req_page_r};
    if (rank_we) rank_mem[rd_idx_r] <= rank_wd;
    fifo_rd_r <= fifo_mem[head_r];
    if (cmd.commit && req_mode_r == MODE_DISCARD && match_r && !free_full) begin
      fifo_mem[tail] <= match_slot_r;
    end
  end

  // result fields
  always_comb begin
    r_status  = 1'b0;
    r_hit     = 1'b0;
    r_fill    = 1'b0;
    r_wb      = 1'b0;
    r_dirty   = 1'b0;
    r_slot    = '0;
    r_wb_slot = '0;
    r_wb_file = '0;
    r_wb_page = '0;
    if (cmd.fout) begin
      r_wb      = 1'b1;
      r_wb_file = tag_rd_r[TAG_W-1:PAGE_W];
      r_wb_page = tag_rd_r[PAGE_W-1:0];
      r_wb_slot = SLOT_W'(idx_r);
    end else begin
      case (req_mode_r)
        MODE_GET: begin
          r_hit  = match_r;
          r_slot = SLOT_W'(prom_slot_r);
          if (!match_r) begin
            r_fill = 1'b1;
            if (!free_nz && dirty_r[prom_slot_r]) begin
              r_wb      = 1'b1;
              r_wb_file = vic_tag_r[TAG_W-1:PAGE_W];
              r_wb_page = vic_tag_r[PAGE_W-1:0];
              r_wb_slot = SLOT_W'(prom_slot_r);
            end
          end
        end
        MODE_MARK: begin
          r_hit    = match_r;
          r_status = !match_r;
        end
        MODE_QUERY: begin
          r_hit    = match_r;
          r_status = !match_r;
          r_dirty  = match_r && dirty_r[match_slot_r];
        end
        MODE_DISCARD: r_hit = match_r;
        MODE_FLUSH_PAGE: begin
          r_hit = match_r;
          if (match_r && dirty_r[match_slot_r]) begin
            r_wb      = 1'b1;
            r_wb_file = req_file_r;
            r_wb_page = req_page_r;
            r_wb_slot = SLOT_W'(match_slot_r);
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_mode_r <= in_tdata[MODE_W-1:0];
      req_file_r <= in_tdata[MODE_W +: FILE_W];
      req_page_r <= in_tdata[MODE_W+FILE_W +: PAGE_W];
    end
    rd_idx_r <= idx_r;
    rd_upd_r <= cmd.upd;
    if (rd_v_r && !rd_upd_r) begin
      if (rd_hit && !match_r) begin
        match_slot_r <= rd_idx_r;
        match_rank_r <= rank_rd_r;
      end
      if (rd_idx_r == '0 || (rd_valid && rank_rd_r > vic_rank_r)) begin
        vic_slot_r <= rd_idx_r;
        vic_rank_r <= rank_rd_r;
        vic_tag_r  <= tag_rd_r;
      end
    end
    if (cmd.decide) begin
      dem_r <= (req_mode_r == MODE_DISCARD);
      if (req_mode_r == MODE_GET && !match_r && free_nz) begin
        prom_slot_r <= fifo_slot;
        prom_rank_r <= match_rank_r;
        prom_all_r  <= 1'b1;
      end else if (req_mode_r == MODE_GET && !match_r) begin
        prom_slot_r <= vic_slot_r;
        prom_rank_r <= vic_rank_r;
        prom_all_r  <= 1'b0;
      end else begin
        prom_slot_r <= match_slot_r;
        prom_rank_r <= match_rank_r;
        prom_all_r  <= 1'b0;
      end
    end
    if (cmd.commit || cmd.fout) begin
      out_tlast_r <= cmd.commit || (flmask_rest == '0);
      out_tdata_r <= OUT_W'({r_dirty, r_wb_slot, r_wb_page, r_wb_file, r_wb,
                             r_fill, r_slot, r_hit, r_status});
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      dirty_r      <= '0;
      fifo_wm_r    <= '0;
      flmask_r     <= '0;
      head_r       <= '0;
      free_cnt_r   <= CNT_W'(NUM_SLOTS);
      idx_r        <= '0;
      rd_v_r       <= 1'b0;
      match_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.sweep_go;
      if (cmd.accept) begin
        idx_r   <= '0;
        match_r <= 1'b0;
      end else if (cmd.sweep_go || cmd.walk_next || cmd.fout) begin
        idx_r <= idx_last ? '0 : idx_r + 1'b1;
      end
      if (rd_v_r && !rd_upd_r) begin
        if (rd_hit) match_r <= 1'b1;
        flmask_r[rd_idx_r] <= rd_valid && dirty_r[rd_idx_r] &&
                              (tag_rd_r[TAG_W-1:PAGE_W] == req_file_r);
      end
      if (cmd.fout) begin
        dirty_r[idx_r]  <= 1'b0;
        flmask_r[idx_r] <= 1'b0;
      end
      if (cmd.commit) begin
        case (req_mode_r)
          MODE_GET: begin
            if (!match_r) begin
              valid_r[prom_slot_r] <= 1'b1;
              dirty_r[prom_slot_r] <= 1'b0;
              if (free_nz) begin
                head_r     <= (head_r == IDX_W'(NUM_SLOTS - 1)) ? '0 : head_r + 1'b1;
                free_cnt_r <= free_cnt_r - 1'b1;
              end
            end
          end
          MODE_MARK: if (match_r) dirty_r[match_slot_r] <= 1'b1;
          MODE_DISCARD: begin
            if (match_r) begin
              valid_r[match_slot_r] <= 1'b0;
              dirty_r[match_slot_r] <= 1'b0;
              if (!free_full) begin
                fifo_wm_r[tail] <= 1'b1;
                free_cnt_r      <= free_cnt_r + 1'b1;
              end
            end
          end
          MODE_FLUSH_PAGE: if (match_r) dirty_r[match_slot_r] <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.commit || cmd.fout) out_tvalid_r <= 1'b1;
      else if (out_tready)        out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

`ifndef SYNTHESIS
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= CNT_W'(NUM_SLOTS))
    else $error("free count above slot count");
  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(valid_r) + int'(free_cnt_r)) == NUM_SLOTS)
    else $error("resident plus free slots mismatch");
  a_dirty_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (dirty_r & ~valid_r) == '0)
    else $error("dirty mark on empty slot");
  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.commit, cmd.fout, cmd.sweep_go, cmd.decide}))
    else $error("conflicting datapath commands");
`endif

endmodule

[tb/sv/lru_page_buffer_controller_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_buffer_controller_tb
// Drives page requests into the LRU buffer controller with random gaps and
// result stalls, tracks tags, dirty marks, ranks and the free-slot FIFO in a
// local copy, and compares every result transfer against it field by field.
// ----------------------------------------------------------------------------
module lru_page_buffer_controller_tb;
  import lpbc_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [FILE_W-1:0] file_id;
    logic [PAGE_W-1:0] page_num;
  } page_req_t;

  typedef struct packed {
    logic              status;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              fill_needed;
    logic              writeback;
    logic [FILE_W-1:0] wb_file;
    logic [PAGE_W-1:0] wb_page;
    logic [SLOT_W-1:0] wb_slot;
    logic              dirty;
    logic              last;
  } page_resp_t;

  logic clk;
  logic rst_n;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tlast;

  lru_page_buffer_controller u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  // shadow of the controller's state
  logic              pg_valid [NSLOT];
  logic [FILE_W-1:0] pg_file  [NSLOT];
  logic [PAGE_W-1:0] pg_page  [NSLOT];
  logic              pg_dirty [NSLOT];
  int                pg_rank  [NSLOT];
  int                free_q   [$];

  page_req_t  req_q  [$];
  page_resp_t resp_q [$];
  int errors = 0;
  int n_sent = 0;
  int n_results = 0;
  int n_wb = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH result %0d %s: got %0h want %0h", n_results, what, got, want);
    errors++;
  endtask

  function automatic int lookup(input logic [FILE_W-1:0] f, input logic [PAGE_W-1:0] p);
    for (int i = 0; i < NSLOT; i++)
      if (pg_valid[i] && pg_file[i] == f && pg_page[i] == p) return i;
    return -1;
  endfunction

  function automatic void make_recent(input int s, input bit was_valid);
    int r;
    r = was_valid ? pg_rank[s] : 1000;
    for (int i = 0; i < NSLOT; i++)
      if (i != s && pg_valid[i] && pg_rank[i] < r) pg_rank[i]++;
    pg_rank[s] = 0;
  endfunction

  // computes the results of one request and updates the shadow state
  function automatic void predict_page_op(input page_req_t rq);
    page_resp_t r;
    int s;
    int rk;
    int n;
    s = (rq.mode <= MODE_FLUSH_PAGE) ? lookup(rq.file_id, rq.page_num) : -1;
    r = '0;
    r.last = 1'b1;
    case (rq.mode)
      MODE_GET: begin
        if (s >= 0) begin
          r.hit = 1'b1;
          make_recent(s, 1'b1);
        end else begin
          if (free_q.size() > 0) begin
            s = free_q[0];
            free_q.delete(0);
            make_recent(s, 1'b0);
          end else begin
            s = 0;
            for (int i = 1; i < NSLOT; i++)
              if (pg_valid[i] && pg_rank[i] > pg_rank[s]) s = i;
            if (pg_dirty[s]) begin
              r.writeback = 1'b1;
              r.wb_file = pg_file[s];
              r.wb_page = pg_page[s];
              r.wb_slot = SLOT_W'(s);
            end
            make_recent(s, 1'b1);
          end
          pg_valid[s] = 1'b1;
          pg_dirty[s] = 1'b0;
          pg_file[s] = rq.file_id;
          pg_page[s] = rq.page_num;
          r.fill_needed = 1'b1;
        end
        r.slot = SLOT_W'(s);
      end
      MODE_MARK: begin
        if (s >= 0) begin r.hit = 1'b1; pg_dirty[s] = 1'b1; end
        else r.status = 1'b1;
      end
      MODE_QUERY: begin
        if (s >= 0) begin r.hit = 1'b1; r.dirty = pg_dirty[s]; end
        else r.status = 1'b1;
      end
      MODE_DISCARD: begin
        if (s >= 0) begin
          rk = pg_rank[s];
          r.hit = 1'b1;
          pg_valid[s] = 1'b0;
          pg_dirty[s] = 1'b0;
          for (int i = 0; i < NSLOT; i++)
            if (pg_valid[i] && pg_rank[i] > rk) pg_rank[i]--;
          if (free_q.size() < NSLOT) free_q.insert(free_q.size(), s);
        end
      end
      MODE_FLUSH_PAGE: begin
        if (s >= 0) begin
          r.hit = 1'b1;
          if (pg_dirty[s]) begin
            r.writeback = 1'b1;
            r.wb_file = pg_file[s];
            r.wb_page = pg_page[s];
            r.wb_slot = SLOT_W'(s);
            pg_dirty[s] = 1'b0;
          end
        end
      end
      MODE_FLUSH_FILE: begin
        n = 0;
        for (int i = 0; i < NSLOT; i++)
          if (pg_valid[i] && pg_dirty[i] && pg_file[i] == rq.file_id) begin
            page_resp_t w;
            w = '0;
            w.writeback = 1'b1;
            w.wb_file = pg_file[i];
            w.wb_page = pg_page[i];
            w.wb_slot = SLOT_W'(i);
            pg_dirty[i] = 1'b0;
            if (n > 0) resp_q.insert(resp_q.size(), r);
            r = w;
            n++;
          end
        r.last = 1'b1;
      end
      default: ;
    endcase
    resp_q.insert(resp_q.size(), r);
  endfunction

  // driver: one request per transfer with a random gap before each
  int in_gap = 0;
  int shown_cnt = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_gap <= 0;
    end else if (in_tvalid && n_sent == shown_cnt) begin
      // hold until the transfer
    end else if (in_tvalid) begin
      // previous item went out; draw the gap before the next one
      in_tvalid <= 1'b0;
      in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
    end else if (req_q.size() > 0) begin
      in_tvalid <= 1'b1;
      in_tdata <= {{(IN_W-IN_BITS){1'b0}}, req_q[0].page_num, req_q[0].file_id,
                   req_q[0].mode};
      shown_cnt <= n_sent;
    end
  end

  // a request leaves the queue on its transfer
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_page_op(req_q[0]);
      req_q.delete(0);
      n_sent++;
    end
  end

  // result stalls
  int out_gap = 0;
  int out_seen = 0;
  always @(negedge clk) begin
    int g;
    g = 0;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
      out_seen <= 0;
    end else begin
      if (n_results != out_seen) begin
        g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        out_seen <= n_results;
      end else if (out_gap > 0) begin
        g = out_gap - 1;
      end
      out_gap <= g;
      out_tready <= (g == 0);
    end
  end

  always @(posedge clk) begin
    page_resp_t got;
    page_resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[0], out_tdata[1], out_tdata[7:2], out_tdata[8], out_tdata[9],
             out_tdata[25:10], out_tdata[57:26], out_tdata[63:58], out_tdata[64],
             out_tlast};
      if (resp_q.size() == 0) begin
        $display("MISMATCH unexpected result %0d", n_results);
        errors++;
      end else begin
        want = resp_q[0];
        resp_q.delete(0);
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.hit != want.hit) report_mismatch("hit", got.hit, want.hit);
        if (got.slot != want.slot) report_mismatch("slot", got.slot, want.slot);
        if (got.fill_needed != want.fill_needed)
          report_mismatch("fill_needed", got.fill_needed, want.fill_needed);
        if (got.writeback != want.writeback)
          report_mismatch("writeback", got.writeback, want.writeback);
        if (got.wb_file != want.wb_file) report_mismatch("wb_file", got.wb_file, want.wb_file);
        if (got.wb_page != want.wb_page) report_mismatch("wb_page", got.wb_page, want.wb_page);
        if (got.wb_slot != want.wb_slot) report_mismatch("wb_slot", got.wb_slot, want.wb_slot);
        if (got.dirty != want.dirty) report_mismatch("dirty", got.dirty, want.dirty);
        if (got.last != want.last) report_mismatch("last", got.last, want.last);
        if (want.writeback) n_wb++;
      end
      n_results++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n && !stim_done) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("lru_page_buffer_controller test failed");
        $finish;
      end
    end
  end

  function automatic void add_req(input logic [MODE_W-1:0] m, input logic [FILE_W-1:0] f,
                                  input logic [PAGE_W-1:0] p);
    page_req_t rq;
    rq.mode = m;
    rq.file_id = f;
    rq.page_num = p;
    req_q.insert(req_q.size(), rq);
  endfunction

  // small working set so hits, evictions and flushes are frequent
  logic [FILE_W-1:0] file_pool [4];
  logic [PAGE_W-1:0] page_pool [8];

  initial begin
    int pick;
    int total;
    rst_n = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      pg_valid[i] = 1'b0;
      pg_dirty[i] = 1'b0;
      pg_file[i] = '0;
      pg_page[i] = '0;
      pg_rank[i] = 0;
      free_q.insert(free_q.size(), i);
    end
    file_pool = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5};
    page_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                  32'h1, 32'h2, 32'h8000_0000, 32'h7FFF_FFFF};
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed: absent pages, extremes, flush of clean and dirty, unused modes
    add_req(MODE_MARK, 16'hFFFF, 32'hFFFF_FFFF);
    add_req(MODE_QUERY, 16'h0000, 32'h0);
    add_req(MODE_DISCARD, 16'h1234, 32'h5);
    add_req(MODE_FLUSH_PAGE, 16'h1234, 32'h5);
    add_req(MODE_FLUSH_FILE, 16'h0000, 32'h0);
    add_req(MODE_GET, 16'h0000, 32'h0);
    add_req(MODE_GET, 16'hFFFF, 32'hFFFF_FFFF);
    add_req(MODE_GET, 16'h0000, 32'h0);
    add_req(MODE_QUERY, 16'hFFFF, 32'hFFFF_FFFF);
    add_req(MODE_FLUSH_PAGE, 16'hFFFF, 32'hFFFF_FFFF);
    add_req(MODE_MARK, 16'hFFFF, 32'hFFFF_FFFF);
    add_req(MODE_QUERY, 16'hFFFF, 32'hFFFF_FFFF);
    add_req(MODE_FLUSH_PAGE, 16'hFFFF, 32'hFFFF_FFFF);
    add_req(MODE_GET, 16'hFFFF, 32'h1);
    add_req(MODE_MARK, 16'hFFFF, 32'h1);
    add_req(MODE_MARK, 16'hFFFF, 32'hFFFF_FFFF);
    add_req(MODE_FLUSH_FILE, 16'hFFFF, 32'hDEAD_BEEF);
    add_req(MODE_DISCARD, 16'h0000, 32'h0);
    add_req(MODE_GET, 16'hABCD, 32'h8000_0000);
    add_req(3'd6, 16'hFFFF, 32'hFFFF_FFFF);
    add_req(3'd7, 16'h0000, 32'h0);

    // fill every slot, then overflow so evictions happen, one of them dirty
    for (int i = 0; i < NSLOT + 2; i++) begin
      add_req(MODE_GET, file_pool[i % 4], 32'h100 + i);
      if (i % 8 == 0) add_req(MODE_MARK, file_pool[i % 4], 32'h100 + i);
    end
    add_req(MODE_FLUSH_FILE, file_pool[0], 32'h0);

    // random: mostly requests on a resident working set, some noise
    total = 0;
    while (total < 12) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)
        add_req(MODE_W'($urandom_range(0, 7)), FILE_W'($urandom), $urandom);
      else if (pick < 3)
        add_req(MODE_GET, file_pool[$urandom_range(0, 3)], 32'h100 + $urandom_range(0, 80));
      else
        add_req(MODE_W'($urandom_range(0, 5)), file_pool[$urandom_range(0, 3)],
                ($urandom_range(0, 1)) ? page_pool[$urandom_range(0, 7)]
                                       : 32'h100 + $urandom_range(0, 80));
      total++;
    end
    add_req(MODE_FLUSH_FILE, file_pool[0], 32'h0);
    add_req(MODE_FLUSH_FILE, file_pool[2], 32'h0);

    wait (req_q.size() == 0 && resp_q.size() == 0);
    fork
      begin
        repeat (400) @(posedge clk);
      end
    join
    stim_done = 1'b1;
    $display("%0d requests sent, %0d results checked, %0d writebacks", n_sent, n_results,
             n_wb);
    if (errors == 0 && resp_q.size() == 0) begin
      $display("lru_page_buffer_controller test passed");
    end else begin
      $display("lru_page_buffer_controller test failed");
    end
    $finish;
  end

endmodule
